@@ design/nss_pkg.sv @@
// Shared types and constants for the note step sequencer.
package nss_pkg;

  // Slot capacity default and configuration register reset values
  localparam int NSS_MAX_SLOTS    = 64;
  localparam int NSS_PERIOD_RST   = 500;
  localparam int NSS_FILL_RST     = 50;
  localparam int NSS_SLOTS_RST    = 64;

  // Widths of the shared divider
  localparam int DIV_W            = 32;
  localparam int DIV_CNT_W        = $clog2(DIV_W);
  localparam int DVSR_W           = 16;

  // Percent scale, the reciprocal used to divide by it, and saturation limits
  localparam int PERCENT          = 100;
  localparam int DIV100_MUL       = 5243;
  localparam int DIV100_SHIFT     = 19;
  localparam int VEL_MAX          = 127;
  localparam int COUNT_MAX        = 127;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_FILL_PERCENT = 2'd1;
  localparam logic [1:0] CFG_SLOT_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_PLAY  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_MUTE  = 2'd3
  } action_e;

  typedef struct packed {
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [15:0] dur;
    logic [3:0]  chan;
  } slot_t;

  typedef struct packed {
    logic        played;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [15:0] dur;
    logic [3:0]  chan;
  } result_t;

endpackage

@@ design/note_step_sequencer_unit.sv @@
// Note step sequencer: slot memory, shared divider and the action sequencer.

// One word in gives one word out. The block works on one word at a time and
// holds in_ready_o low until that word's result is loaded into the output
// register; the next word may then be taken while the result still waits
// for out_ready_i. After reset a clearing pass writes every slot once,
// during which no word is taken (configuration writes are taken as ever).
// Timing is set by the shared restoring divider (one quotient bit a cycle)
// and by the slot memory walk, with one write and one read port:
//   add   : two 32-bit divides, slot read and write, then, if the fill limit
//           is exceeded, a check of each slot above; zero velocity skips all
//   play  : two divides and a slot read (a play inside the step period: none)
//   clear : a write of every slot
//   mute  : read, multiply, scale and write-back for each slot in the count
// The slot index is (time_req / step_period) mod slot_count, worked as two
// passes through the same divider. The fill limit test compares
// slot_count * fill_percent against 100 * note_count, so no division is needed;
// mute scales velocities above level by level/100, multiplying by a reciprocal.
module note_step_sequencer_unit
  import nss_pkg::*;
#(
  parameter int MAX_SLOTS = NSS_MAX_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] time_req_i,
  input  logic [6:0]  note_value_i,
  input  logic [6:0]  velocity_i,
  input  logic [15:0] duration_i,
  input  logic [3:0]  channel_i,
  input  logic [6:0]  mute_level_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        played_o,
  output logic [6:0]  out_note_value_o,
  output logic [6:0]  out_velocity_o,
  output logic [15:0] out_duration_o,
  output logic [3:0]  out_channel_o
);

  // Address width and a slot counter wide enough to hold MAX_SLOTS itself
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int PW = CW + 7;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'b0000_0000_0000_0001,
    ST_INIT  = 16'b0000_0000_0000_0010,
    ST_SWEEP = 16'b0000_0000_0000_0100,
    ST_DIV1  = 16'b0000_0000_0000_1000,
    ST_DIV2  = 16'b0000_0000_0001_0000,
    ST_RDPOS = 16'b0000_0000_0010_0000,
    ST_ADDW  = 16'b0000_0000_0100_0000,
    ST_THR   = 16'b0000_0000_1000_0000,
    ST_EVRD  = 16'b0000_0001_0000_0000,
    ST_EVCK  = 16'b0000_0010_0000_0000,
    ST_PLAYO = 16'b0000_0100_0000_0000,
    ST_MRD   = 16'b0000_1000_0000_0000,
    ST_MM1   = 16'b0001_0000_0000_0000,
    ST_MM2   = 16'b0010_0000_0000_0000,
    ST_MWR   = 16'b0100_0000_0000_0000,
    ST_FIN   = 16'b1000_0000_0000_0000
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         pos_q, pos_d;
  logic [6:0]            count_q, count_d;
  logic [31:0]           last_q, last_d;
  logic [DVSR_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]      acc_q, acc_d;
  logic [DIV_CNT_W-1:0]  dcnt_q, dcnt_d;
  logic [DVSR_W-1:0]     dvsr_q, dvsr_d;
  logic [13:0]           prod_q, prod_d;
  logic [7:0]            scl_q, scl_d;
  result_t               res_q, res_d;
  result_t               out_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic [PW-1:0]         pfill_q;
  logic [15:0]           period_q;
  logic [6:0]            fill_q;
  logic [6:0]            slot_count_q;

  // Word latched at acceptance
  action_e               act_q;
  logic [6:0]            note_q;
  logic [6:0]            vel_q;
  logic [15:0]           dur_q;
  logic [3:0]            chan_q;
  logic [6:0]            level_q;

  // Slot memory
  slot_t                 slot_mem_q [MAX_SLOTS];
  slot_t                 rd_q;
  logic                  mem_we;
  logic [IW-1:0]         mem_wa;
  slot_t                 mem_wd;
  logic                  mem_re;
  logic [IW-1:0]         mem_ra;

  // ---------------------------------------------------------------------------
  // Effective configuration
  // ---------------------------------------------------------------------------
  logic [15:0]           eff_period;
  logic [CW-1:0]         eff_slots;
  logic                  in_accept;
  logic                  play_early;

  assign eff_period = (period_q == 16'd0) ? 16'd1 : period_q;

  always_comb begin
    if (slot_count_q == 7'd0) begin
      eff_slots = CW'(1);
    end else if (32'(slot_count_q) > 32'(MAX_SLOTS)) begin
      eff_slots = CW'(MAX_SLOTS);
    end else begin
      eff_slots = CW'(slot_count_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  // Wrapping time difference against the step period
  assign play_early = ((time_req_i - last_q) < 32'(eff_period));

  // ---------------------------------------------------------------------------
  // Shared divider step: restoring, one quotient bit a cycle
  // ---------------------------------------------------------------------------
  logic [DVSR_W:0]       div_sh;
  logic [DVSR_W+1:0]     div_diff;
  logic                  div_ge;
  logic [DVSR_W-1:0]     div_rem;
  logic [DIV_W-1:0]      div_acc;

  assign div_sh   = {rem_q, acc_q[DIV_W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, dvsr_q};
  assign div_ge   = ~div_diff[DVSR_W+1];
  assign div_rem  = div_ge ? div_diff[DVSR_W-1:0] : div_sh[DVSR_W-1:0];
  assign div_acc  = {acc_q[DIV_W-2:0], div_ge};

  // Mute scaling: divide by 100 through the reciprocal, then saturate
  logic [26:0]           recip;
  logic [6:0]            mute_vel;

  assign recip    = 27'(prod_q) * 27'(DIV100_MUL);
  assign mute_vel = (scl_q > 8'(VEL_MAX)) ? 7'(VEL_MAX) : scl_q[6:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    last_d      = last_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    dcnt_d      = dcnt_q;
    dvsr_d      = dvsr_q;
    prod_d      = prod_q;
    scl_d       = scl_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_q[IW-1:0];
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = idx_q[IW-1:0];

    case (state_q)
      ST_INIT: begin
        // Clearing pass after reset
        mem_we = 1'b1;
        if (idx_q == CW'(MAX_SLOTS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          res_d  = '0;
          acc_d  = time_req_i;
          rem_d  = '0;
          dcnt_d = '0;
          dvsr_d = eff_period;
          case (action_e'(action_i))
            ACT_ADD: begin
              state_d = (velocity_i == 7'd0) ? ST_FIN : ST_DIV1;
            end
            ACT_PLAY: begin
              if (play_early) begin
                state_d = ST_FIN;
              end else begin
                last_d  = time_req_i;
                state_d = ST_DIV1;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
              idx_d   = '0;
              state_d = ST_SWEEP;
            end
            ACT_MUTE: begin
              idx_d   = '0;
              state_d = ST_MRD;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end

      ST_DIV1: begin
        acc_d  = div_acc;
        rem_d  = div_rem;
        dcnt_d = dcnt_q + DIV_CNT_W'(1);
        if (dcnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          // Quotient stays as the next dividend; reduce it by the slot count
          rem_d   = '0;
          dcnt_d  = '0;
          dvsr_d  = DVSR_W'(eff_slots);
          state_d = ST_DIV2;
        end
      end

      ST_DIV2: begin
        acc_d  = div_acc;
        rem_d  = div_rem;
        dcnt_d = dcnt_q + DIV_CNT_W'(1);
        if (dcnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          pos_d   = div_rem[IW-1:0];
          state_d = ST_RDPOS;
        end
      end

      ST_RDPOS: begin
        mem_re  = 1'b1;
        mem_ra  = pos_q;
        state_d = (act_q == ACT_ADD) ? ST_ADDW : ST_PLAYO;
      end

      ST_ADDW: begin
        if (rd_q.vel == 7'd0 && count_q < 7'(COUNT_MAX)) begin
          count_d = count_q + 7'd1;
        end
        mem_we      = 1'b1;
        mem_wa      = pos_q;
        mem_wd.note = note_q;
        mem_wd.vel  = vel_q;
        mem_wd.dur  = dur_q;
        mem_wd.chan = chan_q;
        state_d     = ST_THR;
      end

      ST_THR: begin
        // count > slots*fill/100 is the same as slots*fill < 100*count
        if (32'(pfill_q) < 32'(count_q) * 32'(PERCENT)) begin
          idx_d   = CW'(pos_q) + CW'(1);
          state_d = ST_EVRD;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_EVRD: begin
        if (idx_q < eff_slots) begin
          mem_re  = 1'b1;
          state_d = ST_EVCK;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_EVCK: begin
        // Drop slots of velocity one above the addressed slot
        if (rd_q.vel == 7'd1) begin
          mem_we     = 1'b1;
          mem_wd     = rd_q;
          mem_wd.vel = 7'd0;
          if (count_q != 7'd0) begin
            count_d = count_q - 7'd1;
          end
        end
        idx_d   = idx_q + CW'(1);
        state_d = ST_EVRD;
      end

      ST_PLAYO: begin
        if (rd_q.vel != 7'd0) begin
          res_d.played = 1'b1;
          res_d.note   = rd_q.note;
          res_d.vel    = rd_q.vel;
          res_d.dur    = rd_q.dur;
          res_d.chan   = rd_q.chan;
        end
        state_d = ST_FIN;
      end

      ST_SWEEP: begin
        mem_we = 1'b1;
        if (idx_q == CW'(MAX_SLOTS - 1)) begin
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      ST_MRD: begin
        if (idx_q < eff_slots) begin
          mem_re  = 1'b1;
          state_d = ST_MM1;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_MM1: begin
        prod_d  = 14'(rd_q.vel) * 14'(level_q);
        state_d = ST_MM2;
      end

      ST_MM2: begin
        scl_d   = recip[26:DIV100_SHIFT];
        state_d = ST_MWR;
      end

      ST_MWR: begin
        if (rd_q.vel > level_q) begin
          mem_we     = 1'b1;
          mem_wd     = rd_q;
          mem_wd.vel = mute_vel;
        end
        idx_d   = idx_q + CW'(1);
        state_d = ST_MRD;
      end

      ST_FIN: begin
        // Hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      idx_q       <= '0;
      count_q     <= '0;
      last_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      last_q      <= last_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= 16'(NSS_PERIOD_RST);
      fill_q       <= 7'(NSS_FILL_RST);
      slot_count_q <= 7'(NSS_SLOTS_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_PERIOD:  period_q     <= cfg_data_i;
        CFG_FILL_PERCENT: fill_q       <= cfg_data_i[6:0];
        CFG_SLOT_COUNT:   slot_count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    dvsr_q  <= dvsr_d;
    prod_q  <= prod_d;
    scl_q   <= scl_d;
    res_q   <= res_d;
    pfill_q <= PW'(eff_slots) * PW'(fill_q);
    if (in_accept) begin
      act_q   <= action_e'(action_i);
      note_q  <= note_value_i;
      vel_q   <= velocity_i;
      dur_q   <= duration_i;
      chan_q  <= channel_i;
      level_q <= mute_level_i;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Slot memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= slot_mem_q[mem_ra];
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign out_valid_o      = out_valid_q;
  assign played_o         = out_q.played;
  assign out_note_value_o = out_q.note;
  assign out_velocity_o   = out_q.vel;
  assign out_duration_o   = out_q.dur;
  assign out_channel_o    = out_q.chan;

`ifndef SYNTH
  a_mem_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_wa) < 32'(MAX_SLOTS)))
    else $error("slot write beyond the memory");

  a_played_has_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && played_o) |-> (out_velocity_o != 7'd0))
    else $error("played note carries zero velocity");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !played_o) |->
      (out_note_value_o == 7'd0 && out_velocity_o == 7'd0 &&
       out_duration_o == 16'd0 && out_channel_o == 4'd0))
    else $error("silent result carries slot data");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while the first is in progress");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 7'(COUNT_MAX) && state_q == ST_ADDW) |=> (count_q == 7'(COUNT_MAX)))
    else $error("note count wrapped");
`endif

endmodule
